// ===== sv/fsa_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, command and status codes, and the link memory request type
// for the free-list slot allocator. No dependencies.
package fsa_pkg;

    localparam int SLOTS  = 64;
    localparam int IDX_W  = 6;
    localparam int LINK_W = 7;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_NONE_HELD = 2'd3;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [IDX_W-1:0]  addr;
        logic [LINK_W-1:0] wr_data;
    } link_req_t;

endpackage

// ===== sv/fsa_link_mem.sv =====
`timescale 1ns / 1ps
// Link memory of the free list: one entry per slot, one access per cycle,
// registered read. Entries never written read as their reset link. Uses fsa_pkg.
module fsa_link_mem
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  fsa_pkg::link_req_t            req,
    output logic [fsa_pkg::LINK_W-1:0]    rd_link
);

    logic [fsa_pkg::LINK_W-1:0] mem [fsa_pkg::SLOTS];
    logic [fsa_pkg::SLOTS-1:0]  valid_reg;
    logic [fsa_pkg::LINK_W-1:0] rd_data_reg;
    logic [fsa_pkg::IDX_W-1:0]  rd_addr_reg;
    logic                       rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
            rd_addr_reg <= req.addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_hit_reg <= valid_reg[req.addr];
            end
        end
    end

    // An entry that was never written links to the slot after it.
    assign rd_link = rd_hit_reg ? rd_data_reg
                                : ({1'b0, rd_addr_reg} + fsa_pkg::LINK_W'(1));

endmodule

// ===== sv/free_list_slot_allocator_core.sv =====
`timescale 1ns / 1ps
// Top level of the free-list slot allocator: head, count, control and result register.
// Depends on fsa_pkg and fsa_link_mem.
//
//  Channel  Direction  Handshake            Beat fields
//  in       input      in_valid/in_ready    command, slot_index
//  out      output     out_valid/out_ready  status, granted_index, free_count
//
// A successful acquire passes through the fetch state before the next beat is taken,
// since the new head comes from the link memory read of the granted slot; a release or a rejected command does not.
// The result of each beat is registered at acceptance, and a new beat is taken while it
// waits, provided it is taken in the same cycle.
// After reset all 64 slots are free, linked in index order; no clearing pass is needed.
module free_list_slot_allocator_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [fsa_pkg::IDX_W-1:0]     slot_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [fsa_pkg::IDX_W-1:0]     granted_index,
    output logic [fsa_pkg::LINK_W-1:0]    free_count
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_FETCH = 1'b1;

    localparam logic [fsa_pkg::LINK_W-1:0] SLOTS_L = fsa_pkg::LINK_W'(fsa_pkg::SLOTS);

    logic                          state_reg, state_next;
    logic [fsa_pkg::LINK_W-1:0]    head_reg, head_next;
    logic [fsa_pkg::LINK_W-1:0]    free_total_reg, free_total_next;
    logic                          out_valid_reg, out_valid_next;
    logic [1:0]                    status_reg, status_next;
    logic [fsa_pkg::IDX_W-1:0]     granted_reg, granted_next;
    logic [fsa_pkg::LINK_W-1:0]    count_reg, count_next;

    logic                          in_fire;
    logic                          out_fire;
    logic                          pool_empty;
    logic                          range_bad;
    logic                          acq_ok;
    logic                          rel_ok;
    fsa_pkg::link_req_t            link_req;
    logic [fsa_pkg::LINK_W-1:0]    rd_link;

    fsa_link_mem u_link_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (link_req),
        .rd_link (rd_link)
    );

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    assign pool_empty = (head_reg >= SLOTS_L) || (free_total_reg == '0);
    assign range_bad  = ({1'b0, slot_index} >= SLOTS_L);
    assign acq_ok     = (command == fsa_pkg::CMD_ACQUIRE) && !pool_empty;
    assign rel_ok     = (command == fsa_pkg::CMD_RELEASE) && !range_bad
                        && (free_total_reg < SLOTS_L);

    always_comb
    begin
        link_req.rd_en   = in_fire && acq_ok;
        link_req.wr_en   = in_fire && rel_ok;
        link_req.addr    = (command == fsa_pkg::CMD_ACQUIRE)
                           ? head_reg[fsa_pkg::IDX_W-1:0] : slot_index;
        link_req.wr_data = head_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        free_total_next = free_total_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        granted_next    = granted_reg;
        count_next      = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    out_valid_next = 1'b1;
                    granted_next   = '0;
                    count_next     = free_total_reg;
                    if (command == fsa_pkg::CMD_ACQUIRE)
                    begin
                        if (acq_ok)
                        begin
                            status_next     = fsa_pkg::ST_OK;
                            granted_next    = head_reg[fsa_pkg::IDX_W-1:0];
                            free_total_next = free_total_reg - fsa_pkg::LINK_W'(1);
                            count_next      = free_total_next;
                            state_next      = S_FETCH;
                        end
                        else
                        begin
                            status_next = fsa_pkg::ST_EMPTY;
                        end
                    end
                    else if (range_bad)
                    begin
                        status_next = fsa_pkg::ST_RANGE;
                    end
                    else if (!rel_ok)
                    begin
                        status_next = fsa_pkg::ST_NONE_HELD;
                    end
                    else
                    begin
                        status_next     = fsa_pkg::ST_OK;
                        head_next       = {1'b0, slot_index};
                        free_total_next = free_total_reg + fsa_pkg::LINK_W'(1);
                        count_next      = free_total_next;
                    end
                end
            end
            S_FETCH:
            begin
                head_next  = rd_link;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            free_total_reg <= SLOTS_L;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            free_total_reg <= free_total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        granted_reg <= granted_next;
        count_reg   <= count_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_index = granted_reg;
    assign free_count    = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_total_reg <= SLOTS_L)
        else $error("free count exceeds pool size");

    a_acquire_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && acq_ok |=> state_reg == S_FETCH)
        else $error("granted acquire did not fetch the next head");

    a_fetch_single: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FETCH |=> state_reg == S_IDLE)
        else $error("head fetch lasted more than one cycle");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted beat produced no result");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready && !in_fire |=> out_valid_reg && $stable(count_reg))
        else $error("pending result lost");

endmodule

// ===== dv/free_list_slot_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for free_list_slot_allocator_core: a scoreboard class tracks the
// free list and checks every result beat. Depends on fsa_pkg and the allocator RTL.
module free_list_slot_allocator_core_tb;

    localparam int RANDOM_BEATS = 1950;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;

    typedef struct packed {
        logic [1:0]                 status;
        logic [fsa_pkg::IDX_W-1:0]  granted;
        logic [fsa_pkg::LINK_W-1:0] count;
    } alloc_result_t;

    class slot_pool_scoreboard;
        logic [fsa_pkg::LINK_W-1:0] link_of[fsa_pkg::SLOTS];
        logic [fsa_pkg::LINK_W-1:0] head;
        logic [fsa_pkg::LINK_W-1:0] total;
        bit                         in_use[fsa_pkg::SLOTS];
        alloc_result_t              awaited[$];
        int                         errors;

        function new();
            for (int s = 0; s < fsa_pkg::SLOTS; s++)
            begin
                link_of[s] = fsa_pkg::LINK_W'(s + 1);
                in_use[s]  = 1'b0;
            end
            head   = '0;
            total  = fsa_pkg::LINK_W'(fsa_pkg::SLOTS);
            errors = 0;
        endfunction

        function void note_request(logic cmd, logic [fsa_pkg::IDX_W-1:0] idx);
            alloc_result_t r;
            r = '{status: fsa_pkg::ST_OK, granted: '0, count: '0};
            if (cmd == fsa_pkg::CMD_ACQUIRE)
            begin
                if (head >= fsa_pkg::LINK_W'(fsa_pkg::SLOTS) || total == 0)
                begin
                    r.status = fsa_pkg::ST_EMPTY;
                end
                else
                begin
                    r.granted = head[fsa_pkg::IDX_W-1:0];
                    in_use[head[fsa_pkg::IDX_W-1:0]] = 1'b1;
                    head  = link_of[head[fsa_pkg::IDX_W-1:0]];
                    total = total - 1'b1;
                end
            end
            else if ({1'b0, idx} >= fsa_pkg::LINK_W'(fsa_pkg::SLOTS))
            begin
                r.status = fsa_pkg::ST_RANGE;
            end
            else if (total >= fsa_pkg::LINK_W'(fsa_pkg::SLOTS))
            begin
                r.status = fsa_pkg::ST_NONE_HELD;
            end
            else
            begin
                link_of[idx] = head;
                head         = {1'b0, idx};
                total        = total + 1'b1;
                in_use[idx]  = 1'b0;
            end
            r.count = total;
            awaited.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [fsa_pkg::IDX_W-1:0] g,
                                   logic [fsa_pkg::LINK_W-1:0] c);
            alloc_result_t exp_r;
            if (awaited.size() == 0)
            begin
                $error("result beat with nothing expected: status %0d index %0d count %0d",
                       st, g, c);
                errors++;
                return;
            end
            exp_r = awaited.pop_front();
            if (st !== exp_r.status)
            begin
                $error("status: expected %0d, got %0d", exp_r.status, st);
                errors++;
            end
            if (g !== exp_r.granted)
            begin
                $error("granted_index: expected %0d, got %0d", exp_r.granted, g);
                errors++;
            end
            if (c !== exp_r.count)
            begin
                $error("free_count: expected %0d, got %0d", exp_r.count, c);
                errors++;
            end
        endfunction

        function int held_slot();
            int cands[$];
            for (int s = 0; s < fsa_pkg::SLOTS; s++)
            begin
                if (in_use[s])
                begin
                    cands.push_back(s);
                end
            end
            if (cands.size() == 0)
            begin
                return -1;
            end
            return cands[$urandom_range(cands.size() - 1)];
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic                       command;
    logic [fsa_pkg::IDX_W-1:0]  slot_index;
    logic                       out_valid;
    logic                       out_ready;
    logic [1:0]                 status;
    logic [fsa_pkg::IDX_W-1:0]  granted_index;
    logic [fsa_pkg::LINK_W-1:0] free_count;

    slot_pool_scoreboard sb = new();
    bit calm        = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_active = 1'b0;
    int stall_cycles = 0;

    free_list_slot_allocator_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .slot_index    (slot_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .granted_index (granted_index),
        .free_count    (free_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sb.note_request(command, slot_index);
            end
            if (out_valid && out_ready)
            begin
                sb.check_result(status, granted_index, free_count);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("[free_list_slot_allocator_core] ERROR");
                    $finish;
                end
            end
        end
    end

    task automatic idle_gap();
        while (!(calm || hold_active) && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic send_beat(logic cmd, logic [fsa_pkg::IDX_W-1:0] idx);
        idle_gap();
        command    <= cmd;
        slot_index <= idx;
        in_valid   <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        @(negedge clk);
    endtask

    initial
    begin : receiver
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                out_ready  <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_active = 1'b0;
            end
            else
            begin
                out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 31);
            end
        end
    end

    initial
    begin : stimulus
        logic                      cmd;
        logic [fsa_pkg::IDX_W-1:0] idx;
        int                        held;
        int                        acq_pct;
        in_valid   = 1'b0;
        command    = fsa_pkg::CMD_ACQUIRE;
        slot_index = '0;
        rst_n      = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Releases into a full pool, a double release, and alternating index bits.
        send_beat(fsa_pkg::CMD_RELEASE, 6'd0);
        send_beat(fsa_pkg::CMD_RELEASE, 6'd63);
        send_beat(fsa_pkg::CMD_ACQUIRE, 6'd63);
        send_beat(fsa_pkg::CMD_ACQUIRE, 6'd0);
        send_beat(fsa_pkg::CMD_ACQUIRE, 6'h2A);
        send_beat(fsa_pkg::CMD_RELEASE, 6'd63);
        send_beat(fsa_pkg::CMD_RELEASE, 6'd63);
        send_beat(fsa_pkg::CMD_ACQUIRE, 6'h15);
        send_beat(fsa_pkg::CMD_ACQUIRE, 6'd0);
        send_beat(fsa_pkg::CMD_ACQUIRE, 6'd0);
        send_beat(fsa_pkg::CMD_RELEASE, 6'h2A);
        send_beat(fsa_pkg::CMD_RELEASE, 6'h15);
        send_beat(fsa_pkg::CMD_RELEASE, 6'd1);
        send_beat(fsa_pkg::CMD_RELEASE, 6'd0);
        send_beat(fsa_pkg::CMD_RELEASE, 6'd2);
        send_beat(fsa_pkg::CMD_RELEASE, 6'd63);
        send_beat(fsa_pkg::CMD_RELEASE, 6'd5);

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == 500)
            begin
                hold_req = 1'b1;
            end
            calm = (n >= 1000 && n < 1300);
            case ((n / 130) % 3)
                0:       acq_pct = 88;
                1:       acq_pct = 12;
                default: acq_pct = 50;
            endcase
            if ($urandom_range(99) < 85)
            begin
                held = sb.held_slot();
                if (held < 0 || $urandom_range(99) < acq_pct)
                begin
                    cmd = fsa_pkg::CMD_ACQUIRE;
                    idx = fsa_pkg::IDX_W'($urandom);
                end
                else
                begin
                    cmd = fsa_pkg::CMD_RELEASE;
                    idx = held[fsa_pkg::IDX_W-1:0];
                end
            end
            else
            begin
                cmd = 1'($urandom);
                idx = fsa_pkg::IDX_W'($urandom);
            end
            send_beat(cmd, idx);
        end

        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("[free_list_slot_allocator_core] OK");
        end
        else
        begin
            $display("[free_list_slot_allocator_core] ERROR");
        end
        $finish;
    end

endmodule
